@@ rtl/psc_pkg.sv @@
package psc_pkg;

  localparam int RawW     = 24;
  localparam int CalW     = 16;
  localparam int GainW    = 24;
  localparam int OutW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [GainW-1:0]       DepthGainReset  = 24'd1710801;
  localparam logic signed [OutW-1:0] TempRef         = 32'sd2000;
  // TEMP + 1500 written as (TEMP - 2000) + 3500
  localparam logic signed [19:0]     Cold2Offset     = 20'sd3500;
  localparam logic signed [33:0]     SurfacePressure = 34'sd101300;
  localparam logic [OutW-1:0]        SatMax          = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0]        SatMin          = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SENS   = 3'd5,
    REG_DEPTH_GAIN  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CalW-1:0]  c1;
    logic [CalW-1:0]  c2;
    logic [CalW-1:0]  c3;
    logic [CalW-1:0]  c4;
    logic [CalW-1:0]  c5;
    logic [CalW-1:0]  c6;
    logic [GainW-1:0] depth_gain;
  } cal_t;

  localparam cal_t CalReset = '{
    c1: 16'd0, c2: 16'd0, c3: 16'd0, c4: 16'd0, c5: 16'd0, c6: 16'd0,
    depth_gain: DepthGainReset
  };

  // Hand-off between the temperature and the pressure halves
  typedef struct packed {
    logic                    valid;
    logic [RawW-1:0]         d1;
    logic signed [35:0]      off;
    logic signed [34:0]      sens;
    logic [37:0]             offi;
    logic [36:0]             sensi;
    logic signed [OutW-1:0]  temp2;
  } mid_t;

  typedef struct packed {
    logic signed [OutW-1:0] pressure_decimbar;
    logic signed [OutW-1:0] temperature_centideg;
    logic signed [OutW-1:0] depth_mm;
  } result_t;

endpackage

@@ rtl/psc_if.sv @@
interface psc_in_if;
  logic                         valid;
  logic                         ready;
  logic [psc_pkg::RawW-1:0]     raw_pressure;
  logic [psc_pkg::RawW-1:0]     raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface psc_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [psc_pkg::OutW-1:0] pressure_decimbar;
  logic signed [psc_pkg::OutW-1:0] temperature_centideg;
  logic signed [psc_pkg::OutW-1:0] depth_mm;

  modport source (output valid, pressure_decimbar, temperature_centideg, depth_mm,
                  input ready);
  modport sink   (input valid, pressure_decimbar, temperature_centideg, depth_mm,
                  output ready);
endinterface

@@ rtl/psc_cal_regs.sv @@
module psc_cal_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [psc_pkg::CfgDataW-1:0]   cfg_data,
  output psc_pkg::cal_t                  cal
);

  psc_pkg::cal_t cal_r, cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (psc_pkg::cfg_reg_t'(cfg_index))
        psc_pkg::REG_SENS:        cal_nxt.c1 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_OFFSET:      cal_nxt.c2 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_SENS_TEMP:   cal_nxt.c3 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_OFFSET_TEMP: cal_nxt.c4 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_REF_TEMP:    cal_nxt.c5 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_TEMP_SENS:   cal_nxt.c6 = cfg_data[psc_pkg::CalW-1:0];
        psc_pkg::REG_DEPTH_GAIN:  cal_nxt.depth_gain = cfg_data[psc_pkg::GainW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= psc_pkg::CalReset;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

@@ rtl/psc_temp_stages.sv @@
module psc_temp_stages (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pipe_en,
  input  logic                         in_valid,
  input  logic [psc_pkg::RawW-1:0]     raw_pressure,
  input  logic [psc_pkg::RawW-1:0]     raw_temperature,
  input  psc_pkg::cal_t                cal,
  output psc_pkg::mid_t                mid
);

  logic                         v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [psc_pkg::RawW-1:0]     d1_1_r, d1_2_r, d1_3_r, d1_4_r, d1_5_r;

  logic signed [24:0]           dt_nxt, dt_r;
  logic signed [41:0]           mt_nxt, mt_r, mo_nxt, mo_r, ms_nxt, ms_r;
  logic signed [49:0]           dsq_full;
  logic [47:0]                  dsq_r;

  logic signed [41:0]           mt_adj, mo_adj, ms_adj;
  logic [49:0]                  dsq_x3;
  logic signed [18:0]           q_nxt, q_r;
  logic signed [35:0]           off_nxt, off_3_r, off_4_r, off_5_r;
  logic signed [34:0]           sens_nxt, sens_3_r, sens_4_r, sens_5_r;
  logic [16:0]                  ti_cold_r;
  logic [11:0]                  ti_warm_r;

  logic signed [37:0]           dl2_full;
  logic signed [19:0]           dh;
  logic signed [39:0]           dh2_full;
  logic [34:0]                  dl2_r, dh2_r;
  logic                         cold_r, cold2_r;
  logic [16:0]                  ti_sel;
  logic signed [31:0]           temp2_nxt, temp2_4_r, temp2_5_r;

  logic [36:0]                  dl2_x3, dl2_x5, dh2_x4;
  logic [37:0]                  dh2_x7;
  logic [37:0]                  offi_nxt, offi_r;
  logic [36:0]                  sensi_nxt, sensi_r;

  // stage 1: dT = D2 - C5*256
  assign dt_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});

  // stage 2: coefficient products and dT squared
  always_comb begin
    mt_nxt   = dt_r * $signed({1'b0, cal.c6});
    mo_nxt   = dt_r * $signed({1'b0, cal.c4});
    ms_nxt   = dt_r * $signed({1'b0, cal.c3});
    dsq_full = dt_r * dt_r;
  end

  // stage 3: truncating shifts, TEMP, OFF, SENS and both Ti candidates
  always_comb begin
    mt_adj   = mt_r + {19'd0, {23{mt_r[41]}}};
    mo_adj   = mo_r + {35'd0, {7{mo_r[41]}}};
    ms_adj   = ms_r + {34'd0, {8{ms_r[41]}}};
    q_nxt    = mt_adj[41:23];
    off_nxt  = $signed({4'd0, cal.c2, 16'd0}) + $signed({mo_adj[41], mo_adj[41:7]});
    sens_nxt = $signed({4'd0, cal.c1, 15'd0}) + $signed({ms_adj[41], ms_adj[41:8]});
    dsq_x3   = {1'b0, dsq_r, 1'b0} + {2'b0, dsq_r};
  end

  // stage 4: squares of the temperature distances, second-order TEMP
  always_comb begin
    dl2_full  = q_r * q_r;
    dh        = $signed({q_r[18], q_r}) + psc_pkg::Cold2Offset;
    dh2_full  = dh * dh;
    ti_sel    = q_r[18] ? ti_cold_r : {5'd0, ti_warm_r};
    temp2_nxt = $signed({{13{q_r[18]}}, q_r}) + psc_pkg::TempRef
                - $signed({15'd0, ti_sel});
  end

  // stage 5: OFFi and SENSi
  always_comb begin
    dl2_x3 = {1'b0, dl2_r, 1'b0} + {2'b0, dl2_r};
    dl2_x5 = {dl2_r, 2'b0} + {2'b0, dl2_r};
    dh2_x7 = {dh2_r, 3'b0} - {3'b0, dh2_r};
    dh2_x4 = {dh2_r, 2'b0};
    if (cold_r) begin
      offi_nxt  = {2'b0, dl2_x3[36:1]};
      sensi_nxt = {3'b0, dl2_x5[36:3]};
      if (cold2_r) begin
        offi_nxt  = offi_nxt + dh2_x7;
        sensi_nxt = sensi_nxt + dh2_x4;
      end
    end else begin
      offi_nxt  = {7'd0, dl2_r[34:4]};
      sensi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d1_1_r    <= raw_pressure;
      dt_r      <= dt_nxt;

      d1_2_r    <= d1_1_r;
      mt_r      <= mt_nxt;
      mo_r      <= mo_nxt;
      ms_r      <= ms_nxt;
      dsq_r     <= dsq_full[47:0];

      d1_3_r    <= d1_2_r;
      q_r       <= q_nxt;
      off_3_r   <= off_nxt;
      sens_3_r  <= sens_nxt;
      ti_cold_r <= dsq_x3[49:33];
      ti_warm_r <= dsq_r[47:36];

      d1_4_r    <= d1_3_r;
      off_4_r   <= off_3_r;
      sens_4_r  <= sens_3_r;
      dl2_r     <= dl2_full[34:0];
      dh2_r     <= dh2_full[34:0];
      cold_r    <= q_r[18];
      cold2_r   <= dh[19];
      temp2_4_r <= temp2_nxt;

      d1_5_r    <= d1_4_r;
      off_5_r   <= off_4_r;
      sens_5_r  <= sens_4_r;
      offi_r    <= offi_nxt;
      sensi_r   <= sensi_nxt;
      temp2_5_r <= temp2_4_r;
    end
  end

  always_comb begin
    mid.valid = v5_r;
    mid.d1    = d1_5_r;
    mid.off   = off_5_r;
    mid.sens  = sens_5_r;
    mid.offi  = offi_r;
    mid.sensi = sensi_r;
    mid.temp2 = temp2_5_r;
  end

endmodule

@@ rtl/psc_press_stages.sv @@
module psc_press_stages (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pipe_en,
  input  psc_pkg::mid_t                mid,
  input  logic [psc_pkg::GainW-1:0]    depth_gain,
  output logic                         res_valid,
  output psc_pkg::result_t             res
);

  logic                         v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r, v13_r;
  logic [psc_pkg::RawW-1:0]     d1_6_r;
  logic signed [31:0]           t2_6_r, t2_7_r, t2_8_r, t2_9_r, t2_10_r, t2_11_r, t2_12_r;

  logic signed [38:0]           sdiff_nxt, sdiff_r;
  logic signed [39:0]           odiff_nxt, odiff_6_r, odiff_7_r, odiff_8_r;
  logic [43:0]                  pl_nxt, pl_r;
  logic signed [43:0]           ph_nxt, ph_r;
  logic [63:0]                  prod_nxt, prod_r, prod_adj;
  logic signed [43:0]           y_nxt, y_r, y_adj;
  logic signed [31:0]           p_nxt, p_10_r, p_11_r, p_12_r;
  logic signed [33:0]           p_ext, dm_nxt, dm_r;
  logic signed [58:0]           dprod_nxt, dprod_r;
  logic signed [34:0]           dsh;
  logic signed [31:0]           depth_nxt;
  psc_pkg::result_t             res_r;

  // stage 6: SENS - SENSi and OFF - OFFi
  always_comb begin
    sdiff_nxt = $signed({{4{mid.sens[34]}}, mid.sens}) - $signed({2'b0, mid.sensi});
    odiff_nxt = $signed({{4{mid.off[35]}}, mid.off}) - $signed({2'b0, mid.offi});
  end

  // stage 7: D1 * (SENS - SENSi) as two partial products
  always_comb begin
    pl_nxt = d1_6_r * sdiff_r[19:0];
    ph_nxt = $signed({1'b0, d1_6_r}) * $signed(sdiff_r[38:20]);
  end

  // stage 8: join the partial products
  assign prod_nxt = {ph_r, 20'd0} + {20'd0, pl_r};

  // stage 9: truncate by 2^21, take off OFF - OFFi
  always_comb begin
    prod_adj = prod_r + {43'd0, {21{prod_r[63]}}};
    y_nxt    = $signed({prod_adj[63], prod_adj[63:21]})
               - $signed({{4{odiff_8_r[39]}}, odiff_8_r});
  end

  // stage 10: truncate by 2^13 gives P
  always_comb begin
    y_adj = y_r + $signed({31'd0, {13{y_r[43]}}});
    p_nxt = $signed({y_adj[43], y_adj[43:13]});
  end

  // stage 11: 10*P - surface pressure
  always_comb begin
    p_ext  = $signed({{2{p_10_r[31]}}, p_10_r});
    dm_nxt = (p_ext <<< 3) + (p_ext <<< 1) - psc_pkg::SurfacePressure;
  end

  // stage 12: depth scale
  assign dprod_nxt = dm_r * $signed({1'b0, depth_gain});

  // stage 13: floor shift by 24 and clamp
  always_comb begin
    dsh = dprod_r[58:24];
    if (dsh[34:31] == 4'b0000 || dsh[34:31] == 4'b1111) begin
      depth_nxt = dsh[31:0];
    end else if (dsh[34]) begin
      depth_nxt = psc_pkg::SatMin;
    end else begin
      depth_nxt = psc_pkg::SatMax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else if (pipe_en) begin
      v6_r  <= mid.valid;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d1_6_r    <= mid.d1;
      sdiff_r   <= sdiff_nxt;
      odiff_6_r <= odiff_nxt;
      t2_6_r    <= mid.temp2;

      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
      odiff_7_r <= odiff_6_r;
      t2_7_r    <= t2_6_r;

      prod_r    <= prod_nxt;
      odiff_8_r <= odiff_7_r;
      t2_8_r    <= t2_7_r;

      y_r       <= y_nxt;
      t2_9_r    <= t2_8_r;

      p_10_r    <= p_nxt;
      t2_10_r   <= t2_9_r;

      dm_r      <= dm_nxt;
      p_11_r    <= p_10_r;
      t2_11_r   <= t2_10_r;

      dprod_r   <= dprod_nxt;
      p_12_r    <= p_11_r;
      t2_12_r   <= t2_11_r;

      res_r.pressure_decimbar    <= p_12_r;
      res_r.temperature_centideg <= t2_12_r;
      res_r.depth_mm             <= depth_nxt;
    end
  end

  assign res_valid = v13_r;
  assign res       = res_r;

endmodule

@@ rtl/psc_out_skid.sv @@
module psc_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  psc_pkg::result_t  up_data,
  output logic              pipe_en,
  output logic              out_valid,
  input  logic              out_ready,
  output psc_pkg::result_t  out_data
);

  logic             out_v_r, out_v_nxt, sk_v_r, sk_v_nxt, take;
  psc_pkg::result_t out_d_r, out_d_nxt, sk_d_r, sk_d_nxt;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    take      = out_v_r && out_ready;
    if (sk_v_r) begin
      // pipeline is frozen; refill the output from the skid beat
      if (take) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (up_valid) begin
      if (!out_v_r || take) begin
        out_d_nxt = up_data;
        out_v_nxt = 1'b1;
      end else begin
        sk_d_nxt = up_data;
        sk_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign pipe_en   = !sk_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

@@ rtl/pressure_sensor_compensation.sv @@
// Channel   Dir  Handshake     Beat contents
// in_chan   in   valid/ready   raw_pressure (D1, 24b), raw_temperature (D2, 24b)
// out_chan  out  valid/ready   pressure_decimbar, temperature_centideg, depth_mm (32b s)
// cfg_*     in   cfg_we only   cfg_index 0..6, cfg_data up to 24b, no read-back
//
// One beat is accepted per cycle while no beat sits in the skid register; a result passes
// through 13 arithmetic stages (at most one multiplier level per stage), the first loaded
// at the edge that accepts its input beat, then the output register.
// Reset is synchronous, active low: clears valid bits, calibration words to 0 and
// depth_gain to its default.
// A stalled output parks one beat in a skid register and freezes the pipeline;
// in_chan.ready comes straight from a flop and drops only while that beat is parked.
module pressure_sensor_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  psc_in_if.sink                         in_chan,
  psc_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [psc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [psc_pkg::CfgDataW-1:0]   cfg_data
);

  psc_pkg::cal_t     cal;
  psc_pkg::mid_t     mid;
  psc_pkg::result_t  res, out_data;
  logic              res_valid, pipe_en, out_valid;

  psc_cal_regs u_cal_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  psc_temp_stages u_temp_stages (
    .clk             (clk),
    .rst_n           (rst_n),
    .pipe_en         (pipe_en),
    .in_valid        (in_chan.valid),
    .raw_pressure    (in_chan.raw_pressure),
    .raw_temperature (in_chan.raw_temperature),
    .cal             (cal),
    .mid             (mid)
  );

  psc_press_stages u_press_stages (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_en    (pipe_en),
    .mid        (mid),
    .depth_gain (cal.depth_gain),
    .res_valid  (res_valid),
    .res        (res)
  );

  psc_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (res_valid),
    .up_data   (res),
    .pipe_en   (pipe_en),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign in_chan.ready                 = pipe_en;
  assign out_chan.valid                = out_valid;
  assign out_chan.pressure_decimbar    = out_data.pressure_decimbar;
  assign out_chan.temperature_centideg = out_data.temperature_centideg;
  assign out_chan.depth_mm             = out_data.depth_mm;

endmodule

@@ rtl/psc_checker.sv @@
module psc_port_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [psc_pkg::OutW-1:0] out_pressure_decimbar,
  input logic signed [psc_pkg::OutW-1:0] out_temperature_centideg,
  input logic signed [psc_pkg::OutW-1:0] out_depth_mm
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_decimbar)
      && $stable(out_temperature_centideg) && $stable(out_depth_mm))
    else $error("result changed or vanished while stalled");

  // input side closes only behind a waiting result
  a_ready_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  // without an output stall the input side stays open
  a_ready_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && (!out_valid || out_ready) |=> in_ready)
    else $error("input closed without an output stall");

  // a taken result reopens the input side at once
  a_ready_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("input stayed closed after the output drained");

endmodule

bind pressure_sensor_compensation psc_port_props u_psc_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_ready                 (in_chan.ready),
  .out_valid                (out_chan.valid),
  .out_ready                (out_chan.ready),
  .out_pressure_decimbar    (out_chan.pressure_decimbar),
  .out_temperature_centideg (out_chan.temperature_centideg),
  .out_depth_mm             (out_chan.depth_mm)
);

@@ test/psc_checker.sv @@
`timescale 1ns / 100ps

module psc_checker
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  psc_in_if                   in_mon,
  psc_out_if                  out_mon,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam longint Pow21 = 64'sd2097152;
  localparam longint Pow23 = 64'sd8388608;
  localparam longint Pow33 = 64'sd8589934592;
  localparam longint Pow37 = 64'sd137438953472;
  localparam longint DepthHi = 64'sd2147483647;
  localparam longint DepthLo = -64'sd2147483648;

  cal_t    cal_shadow;
  result_t expected_readings[$];
  result_t got;
  result_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic result_t compensate(input logic [RawW-1:0] d1_raw,
                                         input logic [RawW-1:0] d2_raw,
                                         input cal_t c);
    longint d1, dt, temp, off, sens, ti, offi, sensi, dl, dh, p, temp2, depth;
    result_t r;
    d1   = longint'({40'd0, d1_raw});
    dt   = longint'({40'd0, d2_raw}) - longint'({40'd0, c.c5, 8'd0});
    temp = 2000 + dt * longint'({48'd0, c.c6}) / Pow23;
    off  = longint'({48'd0, c.c2}) * 65536 + longint'({48'd0, c.c4}) * dt / 128;
    sens = longint'({48'd0, c.c1}) * 32768 + longint'({48'd0, c.c3}) * dt / 256;
    dl   = temp - 2000;
    if (temp < 2000) begin
      ti    = 3 * dt * dt / Pow33;
      offi  = 3 * dl * dl / 2;
      sensi = 5 * dl * dl / 8;
      // very cold: add the extra low-temperature terms
      if (temp < -1500) begin
        dh    = temp + 1500;
        offi  = offi + 7 * dh * dh;
        sensi = sensi + 4 * dh * dh;
      end
    end else begin
      ti    = 2 * dt * dt / Pow37;
      offi  = dl * dl / 16;
      sensi = 0;
    end
    p     = (d1 * (sens - sensi) / Pow21 - (off - offi)) / 8192;
    temp2 = temp - ti;
    // floor shift, then clamp to 32 bits
    depth = ((10 * p - 101300) * longint'({40'd0, c.depth_gain})) >>> 24;
    if (depth > DepthHi) depth = DepthHi;
    else if (depth < DepthLo) depth = DepthLo;
    r.pressure_decimbar    = p[OutW-1:0];
    r.temperature_centideg = temp2[OutW-1:0];
    r.depth_mm             = depth[OutW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string field, input logic signed [OutW-1:0] seen,
                             input logic signed [OutW-1:0] model);
    if (seen !== model)
      report_mismatch($sformatf("%s got %0d, want %0d", field, seen, model));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_shadow = CalReset;
      expected_readings.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.pressure_decimbar    = out_mon.pressure_decimbar;
        got.temperature_centideg = out_mon.temperature_centideg;
        got.depth_mm             = out_mon.depth_mm;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending (P=%0d T=%0d D=%0d)",
                                    got.pressure_decimbar, got.temperature_centideg,
                                    got.depth_mm));
        end else begin
          want = expected_readings.pop_front();
          check_field("pressure_decimbar", got.pressure_decimbar, want.pressure_decimbar);
          check_field("temperature_centideg", got.temperature_centideg,
                      want.temperature_centideg);
          check_field("depth_mm", got.depth_mm, want.depth_mm);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_readings.push_back(compensate(in_mon.raw_pressure, in_mon.raw_temperature,
                                               cal_shadow));
      if (cfg_we) begin
        case (cfg_index)
          REG_SENS:        cal_shadow.c1 = cfg_data[CalW-1:0];
          REG_OFFSET:      cal_shadow.c2 = cfg_data[CalW-1:0];
          REG_SENS_TEMP:   cal_shadow.c3 = cfg_data[CalW-1:0];
          REG_OFFSET_TEMP: cal_shadow.c4 = cfg_data[CalW-1:0];
          REG_REF_TEMP:    cal_shadow.c5 = cfg_data[CalW-1:0];
          REG_TEMP_SENS:   cal_shadow.c6 = cfg_data[CalW-1:0];
          REG_DEPTH_GAIN:  cal_shadow.depth_gain = cfg_data[GainW-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_readings.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import psc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
  localparam int IdlePct     = 23;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 80;
  localparam int Phases      = 5;
  localparam int RandomItems = 1100;
  localparam int DrainCycles = 30;

  // seawater depth scale
  localparam cal_t DatasheetCal = '{
    c1: 16'd34982, c2: 16'd36352, c3: 16'd20328, c4: 16'd22354, c5: 16'd26646,
    c6: 16'd26785, depth_gain: 24'd1662584
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                quiet = 1'b0;
  int                  hold_requests = 0;
  int                  stall_cycles = 0;
  int                  errors;
  int                  pending;

  psc_in_if  in_chan ();
  psc_out_if out_chan ();

  pressure_sensor_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  psc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && served != hold_requests) begin
        served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called and returns at a falling edge
  task automatic send_sample(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.raw_pressure    <= d1;
    in_chan.raw_temperature <= d2;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Upper data bits are junk on the 16-bit words; the block must drop them
  task automatic load_calibration(input cal_t c);
    write_reg(REG_SENS,        {8'($urandom), c.c1});
    write_reg(REG_OFFSET,      {8'($urandom), c.c2});
    write_reg(REG_SENS_TEMP,   {8'($urandom), c.c3});
    write_reg(REG_OFFSET_TEMP, {8'($urandom), c.c4});
    write_reg(REG_REF_TEMP,    {8'($urandom), c.c5});
    write_reg(REG_TEMP_SENS,   {8'($urandom), c.c6});
    write_reg(REG_DEPTH_GAIN,  c.depth_gain);
    write_reg(RegSpare,        CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    cal_t            cal;
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
    int              t;

    in_chan.valid           = 1'b0;
    in_chan.raw_pressure    = '0;
    in_chan.raw_temperature = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // uncalibrated: reset words
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'h800000, 24'h7FFFFF);

    drain();
    load_calibration(DatasheetCal);
    send_sample(24'd4958179, 24'd6815414);
    send_sample(24'd4958179, 24'd6821376);  // TEMP exactly 2000
    send_sample(24'd4958179, 24'd6821062);  // TEMP 1999
    send_sample(24'd4958179, 24'd5724923);  // TEMP -1500, not yet very cold
    send_sample(24'd4958179, 24'd5724922);  // TEMP -1501
    send_sample(24'd4958179, 24'd2000000);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'd1, 24'd6821377);

    drain();
    load_calibration('1);
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);

    drain();
    load_calibration('0);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'h123456, 24'hABCDEF);

    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      case (ph)
        0: cal = DatasheetCal;
        3: cal = '1;
        default: begin
          cal.c1 = CalW'($urandom);
          cal.c2 = CalW'($urandom);
          cal.c3 = CalW'($urandom);
          cal.c4 = CalW'($urandom);
          cal.c5 = CalW'($urandom);
          cal.c6 = CalW'($urandom);
          cal.depth_gain = GainW'($urandom);
        end
      endcase
      if (ph == 4) cal.depth_gain = '0;
      load_calibration(cal);
      quiet <= (ph == 1);
      if (ph == 0) hold_requests <= hold_requests + 1;
      for (int n = 0; n < RandomItems / Phases; n++) begin
        d1 = RawW'($urandom);
        if ($urandom_range(1) == 1) begin
          d2 = RawW'($urandom);
        end else begin
          // land near the reference reading so both branches and the cold case show up
          t = int'({cal.c5, 8'd0}) + int'($urandom_range(0, 1 << 21)) - (1 << 20);
          if (t < 0) t = 0;
          else if (t > 16777215) t = 16777215;
          d2 = t[RawW-1:0];
        end
        send_sample(d1, d2);
      end
    end

    drain();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/psc_pkg.sv
rtl/psc_if.sv
rtl/psc_cal_regs.sv
rtl/psc_temp_stages.sv
rtl/psc_press_stages.sv
rtl/psc_out_skid.sv
rtl/pressure_sensor_compensation.sv
rtl/psc_checker.sv
test/psc_checker.sv
test/tb_top.sv
